[rtl/zhpb_pkg.sv]
// ----------------------------------------------------------------------------
// zhpb_pkg
// Types, constants, direction maps and helper functions shared by the
// Zou-He fixed-pressure boundary pipeline.
// ----------------------------------------------------------------------------
package zhpb_pkg;

  localparam int DW  = 32;
  localparam int XW  = 40;
  localparam int YW  = 42;
  localparam int NCH = 3;
  localparam int CW  = YW / NCH;
  localparam int NLANE = 3;
  localparam int RSH = CW + 3;
  localparam int REC = ((1 << RSH) + 2) / 3;

  localparam logic [YW-1:0] OFFSET = YW'(64'd3 << (XW - 1));

  typedef logic signed [XW-1:0] wide_t;
  typedef logic signed [YW:0]   quot_t;

  localparam quot_t BIAS = quot_t'(64'sd1 <<< (XW - 1));
  localparam quot_t QMAX = quot_t'((64'sd1 <<< (DW - 1)) - 64'sd1);
  localparam quot_t QMIN = -QMAX - quot_t'(1);

  typedef enum logic [2:0] {
    OP_NORTH, OP_SOUTH, OP_WEST, OP_EAST, OP_NW, OP_NE, OP_SW, OP_SE
  } op_e;

  typedef enum logic [1:0] {
    CFG_NORTH, CFG_SOUTH, CFG_WEST, CFG_EAST
  } cfg_e;

  typedef logic [3:0] dir_t;
  typedef logic [8:0][DW-1:0] dist_t;
  typedef logic [3:0][DW-1:0] dens_t;

  localparam dir_t SIDE_MAP [4][8] = '{
    '{4'd7, 4'd3, 4'd6, 4'd2, 4'd8, 4'd4, 4'd1, 4'd5},
    '{4'd3, 4'd7, 4'd2, 4'd6, 4'd4, 4'd8, 4'd5, 4'd1},
    '{4'd1, 4'd5, 4'd2, 4'd6, 4'd8, 4'd4, 4'd7, 4'd3},
    '{4'd5, 4'd1, 4'd6, 4'd2, 4'd4, 4'd8, 4'd3, 4'd7}
  };

  localparam dir_t CORNER_MAP [4][8] = '{
    '{4'd1, 4'd5, 4'd7, 4'd3, 4'd8, 4'd4, 4'd2, 4'd6},
    '{4'd5, 4'd1, 4'd6, 4'd2, 4'd7, 4'd3, 4'd4, 4'd8},
    '{4'd1, 4'd5, 4'd2, 4'd6, 4'd3, 4'd7, 4'd4, 4'd8},
    '{4'd3, 4'd7, 4'd4, 4'd8, 4'd5, 4'd1, 4'd2, 4'd6}
  };

  typedef struct packed {
    logic [2:0]    operation;
    logic [DW-1:0] dist_in_0;
    logic [DW-1:0] dist_in_1;
    logic [DW-1:0] dist_in_2;
    logic [DW-1:0] dist_in_3;
    logic [DW-1:0] dist_in_4;
    logic [DW-1:0] dist_in_5;
    logic [DW-1:0] dist_in_6;
    logic [DW-1:0] dist_in_7;
    logic [DW-1:0] dist_in_8;
  } item_t;

  typedef struct packed {
    logic [DW-1:0] dist_out_0;
    logic [DW-1:0] dist_out_1;
    logic [DW-1:0] dist_out_2;
    logic [DW-1:0] dist_out_3;
    logic [DW-1:0] dist_out_4;
    logic [DW-1:0] dist_out_5;
    logic [DW-1:0] dist_out_6;
    logic [DW-1:0] dist_out_7;
    logic [DW-1:0] dist_out_8;
  } result_t;

  typedef struct packed {
    op_e           op;
    logic          rho_pos;
    logic [DW-1:0] rho;
    dist_t         f;
  } stage_a_t;

  typedef struct packed {
    op_e   op;
    logic  rho_pos;
    dist_t f;
    wide_t base;
    wide_t tan;
  } stage_b_t;

  typedef struct packed {
    op_e                        op;
    logic                       rho_pos;
    dist_t                      f;
    logic [NLANE-1:0][YW-1:0]   w;
    logic [NLANE-1:0][1:0]      r;
  } div_t;

  typedef struct packed {
    logic [CW-1:0] q;
    logic [1:0]    r;
  } div3_t;

  function automatic wide_t sx(input logic [DW-1:0] v);
    return wide_t'($signed(v));
  endfunction

  function automatic logic is_corner(input op_e op);
    return op >= OP_NW;
  endfunction

  function automatic div3_t div3(input logic [1:0] rin, input logic [CW-1:0] c);
    logic [CW+1:0]  val;
    logic [2*CW+3:0] prod;
    logic [CW+1:0]  rem;
    div3_t          res;
    val   = {rin, c};
    prod  = (2*CW+4)'(val) * (2*CW+4)'(REC);
    res.q = prod[RSH +: CW];
    rem   = val - (CW+2)'(3) * (CW+2)'(res.q);
    res.r = rem[1:0];
    return res;
  endfunction

endpackage

[rtl/zhpb_front.sv]
// ----------------------------------------------------------------------------
// zhpb_front
// First three pipeline stages: density select, momentum sums, and the
// biased numerators that feed the divide-by-three stages.
// ----------------------------------------------------------------------------
module zhpb_front (
  input  logic            clk,
  input  logic [2:0]      en,
  input  zhpb_pkg::item_t item,
  input  zhpb_pkg::dens_t dens,
  output zhpb_pkg::div_t  c
);
  import zhpb_pkg::*;

  stage_a_t a, a_next;
  stage_b_t b, b_next;
  div_t     c_next;

  always_comb begin
    a_next.op = op_e'(item.operation);
    a_next.f  = {item.dist_in_8, item.dist_in_7, item.dist_in_6, item.dist_in_5,
                 item.dist_in_4, item.dist_in_3, item.dist_in_2, item.dist_in_1,
                 item.dist_in_0};
    unique case (a_next.op)
      OP_NORTH, OP_NW, OP_NE: a_next.rho = dens[CFG_NORTH];
      OP_SOUTH, OP_SW, OP_SE: a_next.rho = dens[CFG_SOUTH];
      OP_WEST:                a_next.rho = dens[CFG_WEST];
      default:                a_next.rho = dens[CFG_EAST];
    endcase
    a_next.rho_pos = !a_next.rho[DW-1] && (a_next.rho != '0);
  end

  always_comb begin
    dir_t  sm [8];
    dir_t  cm [8];
    wide_t fa, fb, s;
    sm = SIDE_MAP[a.op[1:0]];
    cm = CORNER_MAP[a.op[1:0]];
    fa = sx(a.f[sm[6]]);
    fb = sx(a.f[sm[7]]);
    s  = '0;
    b_next.op      = a.op;
    b_next.rho_pos = a.rho_pos;
    b_next.f       = a.f;
    if (is_corner(a.op)) begin
      b_next.base = sx(a.rho) - sx(a.f[0])
                    - 2 * (sx(a.f[cm[1]]) + sx(a.f[cm[3]]) + sx(a.f[cm[5]]));
      b_next.tan  = '0;
    end else begin
      s = sx(a.f[0]) + fa + fb
          + 2 * (sx(a.f[sm[1]]) + sx(a.f[sm[3]]) + sx(a.f[sm[5]]));
      b_next.base = sx(a.rho) - s;
      b_next.tan  = 3 * (fa - fb);
    end
  end

  always_comb begin
    dir_t  m [8];
    wide_t xa, xb, xc, v;
    m  = SIDE_MAP[b.op[1:0]];
    v  = (b.base + 1) >>> 1;
    if (is_corner(b.op)) begin
      xa = 3 * v;
      xb = '0;
      xc = '0;
    end else begin
      xa = 3 * sx(b.f[m[1]]) + 2 * b.base + 1;
      xb = (6 * sx(b.f[m[3]]) + b.base + b.tan + 3) >>> 1;
      xc = (6 * sx(b.f[m[5]]) + b.base - b.tan + 3) >>> 1;
    end
    c_next.op      = b.op;
    c_next.rho_pos = b.rho_pos;
    c_next.f       = b.f;
    c_next.w[0]    = YW'(xa) + OFFSET;
    c_next.w[1]    = YW'(xb) + OFFSET;
    c_next.w[2]    = YW'(xc) + OFFSET;
    c_next.r       = '0;
  end

  always_ff @(posedge clk) begin
    if (en[0]) a <= a_next;
    if (en[1]) b <= b_next;
    if (en[2]) c <= c_next;
  end

endmodule

[rtl/zhpb_div.sv]
// ----------------------------------------------------------------------------
// zhpb_div
// Long division by three over the three lanes, one chunk of the biased
// numerator per stage, most significant chunk first.
// ----------------------------------------------------------------------------
module zhpb_div (
  input  logic                       clk,
  input  logic [zhpb_pkg::NCH-1:0]   en,
  input  zhpb_pkg::div_t             din,
  output zhpb_pkg::div_t             dout
);
  import zhpb_pkg::*;

  div_t st [NCH+1];

  assign st[0] = din;
  assign dout  = st[NCH];

  for (genvar k = 0; k < NCH; k++) begin : g_stage
    localparam int HI = YW - 1 - k * CW;
    div_t nxt;

    always_comb begin
      div3_t d;
      nxt = st[k];
      for (int l = 0; l < NLANE; l++) begin
        d = div3(st[k].r[l], st[k].w[l][HI -: CW]);
        nxt.w[l][HI -: CW] = d.q;
        nxt.r[l]           = d.r;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) st[k+1] <= nxt;
    end
  end

endmodule

[rtl/zhpb_assemble.sv]
// ----------------------------------------------------------------------------
// zhpb_assemble
// Output stage: removes the bias, saturates each rebuilt value and places
// it or a copied input in the unknown directions; zero if rho is not positive.
// ----------------------------------------------------------------------------
module zhpb_assemble (
  input  logic              clk,
  input  logic              en,
  input  zhpb_pkg::div_t    din,
  output zhpb_pkg::result_t result
);
  import zhpb_pkg::*;

  result_t nxt;

  always_comb begin
    logic [NLANE-1:0][DW-1:0] v;
    quot_t                    d;
    dir_t                     m [8];
    dist_t                    o;
    for (int l = 0; l < NLANE; l++) begin
      d = $signed({1'b0, din.w[l]}) - BIAS;
      if (d > QMAX) d = QMAX;
      if (d < QMIN) d = QMIN;
      v[l] = d[DW-1:0];
    end
    o = din.f;
    if (is_corner(din.op)) begin
      m = CORNER_MAP[din.op[1:0]];
      o[m[0]] = din.rho_pos ? din.f[m[1]] : '0;
      o[m[2]] = din.rho_pos ? din.f[m[3]] : '0;
      o[m[4]] = din.rho_pos ? din.f[m[5]] : '0;
      o[m[6]] = din.rho_pos ? v[0] : '0;
      o[m[7]] = din.rho_pos ? v[0] : '0;
    end else begin
      m = SIDE_MAP[din.op[1:0]];
      o[m[0]] = din.rho_pos ? v[0] : '0;
      o[m[2]] = din.rho_pos ? v[1] : '0;
      o[m[4]] = din.rho_pos ? v[2] : '0;
    end
    nxt = {o[0], o[1], o[2], o[3], o[4], o[5], o[6], o[7], o[8]};
  end

  always_ff @(posedge clk) begin
    if (en) result <= nxt;
  end

endmodule

[rtl/zou_he_pressure_boundary_unit.sv]
// ----------------------------------------------------------------------------
// zou_he_pressure_boundary_unit
// Zou-He fixed-pressure boundary rule for D2Q9 boundary cells.
// ----------------------------------------------------------------------------
// An item carries an operation code that names a side or corner and the nine
// incoming distributions. A transfer on the item channel happens when
// item_valid is high and item_stall is low; a result transfer happens when
// result_valid is high and result_stall is low. Each item gives one result.
// The pipeline has seven register stages, and one item per cycle is taken
// in steady state while result_stall stays low.
// The depth is three front stages, the three chunk stages of the
// divide-by-three and the output register.
// Each stage holds its item while the stage after it is full and stalled,
// so bubbles close up and a stalled result is held without loss.
// The four densities are written through cfg_write, cfg_index and cfg_data
// and take effect for items that transfer afterward.
// Synchronous reset empties the pipeline and sets every density to 1.0.
// ----------------------------------------------------------------------------
module zou_he_pressure_boundary_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  zhpb_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output zhpb_pkg::result_t result,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data
);
  import zhpb_pkg::*;

  localparam int NST = 3 + NCH + 1;
  localparam logic [DW-1:0] RHO_ONE = DW'(134217728);

  logic [NST-1:0] valid;
  logic [NST-1:0] rdy;
  dens_t          dens;
  div_t           front_out;
  div_t           div_out;

  always_comb begin
    rdy[NST-1] = !valid[NST-1] || !result_stall;
    for (int k = NST - 2; k >= 0; k--) begin
      rdy[k] = !valid[k] || rdy[k+1];
    end
  end

  assign item_stall   = !rdy[0];
  assign result_valid = valid[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (rdy[0]) valid[0] <= item_valid;
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) valid[k] <= valid[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dens <= {RHO_ONE, RHO_ONE, RHO_ONE, RHO_ONE};
    end else if (cfg_write) begin
      unique case (cfg_e'(cfg_index))
        CFG_NORTH: dens[CFG_NORTH] <= cfg_data;
        CFG_SOUTH: dens[CFG_SOUTH] <= cfg_data;
        CFG_WEST:  dens[CFG_WEST]  <= cfg_data;
        CFG_EAST:  dens[CFG_EAST]  <= cfg_data;
        default:   dens <= dens;
      endcase
    end
  end

  zhpb_front u_front (
    .clk  (clk),
    .en   (rdy[2:0]),
    .item (item),
    .dens (dens),
    .c    (front_out)
  );

  zhpb_div u_div (
    .clk  (clk),
    .en   (rdy[3 +: NCH]),
    .din  (front_out),
    .dout (div_out)
  );

  zhpb_assemble u_assemble (
    .clk    (clk),
    .en     (rdy[NST-1]),
    .din    (div_out),
    .result (result)
  );

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> valid[0])
    else $error("accepted item did not enter the first stage");

  a_hold_when_blocked: assert property (@(posedge clk) disable iff (rst)
    valid[2] && !rdy[2] |=> valid[2])
    else $error("blocked stage dropped its item");

  a_stall_holds_output: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

endmodule

[tb/tb_zou_he_pressure_boundary_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_zou_he_pressure_boundary_unit
// Checks the Zou-He pressure boundary unit against a behavioral predictor.
// Directed cells cover every side and corner, field extremes and densities that
// are not positive. Random cells follow under several density settings, some with
// random idling on both channels. Every result is compared field by field.
// ----------------------------------------------------------------------------
module tb_zou_he_pressure_boundary_unit;
  import zhpb_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  item_t       item = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  result_t     result;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = 2'd0;
  logic [31:0] cfg_data = '0;

  zou_he_pressure_boundary_unit i_dut (
    .clk, .rst, .item_valid, .item_stall, .item, .result_valid, .result_stall,
    .result, .cfg_write, .cfg_index, .cfg_data
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic signed [31:0] density [4];
  item_t   pending_cells [$];
  result_t expected_cells [$];
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  bit      hold_send = 1'b0;
  int      errors = 0;
  longint  cycles = 0;

  function automatic logic [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic longint round_div(input longint n, input longint d);
    longint a, b, q;
    a = 2 * n + d;
    b = 2 * d;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic result_t boundary_rule(input item_t c);
    longint f [9];
    logic [31:0] o [9];
    int m [8];
    longint rho, s, q, t;
    logic [31:0] v;
    op_e op;
    result_t r;
    f[0] = longint'($signed(c.dist_in_0)); f[1] = longint'($signed(c.dist_in_1));
    f[2] = longint'($signed(c.dist_in_2)); f[3] = longint'($signed(c.dist_in_3));
    f[4] = longint'($signed(c.dist_in_4)); f[5] = longint'($signed(c.dist_in_5));
    f[6] = longint'($signed(c.dist_in_6)); f[7] = longint'($signed(c.dist_in_7));
    f[8] = longint'($signed(c.dist_in_8));
    for (int i = 0; i < 9; i++) o[i] = f[i][31:0];
    op = op_e'(c.operation);
    case (op)
      OP_NORTH, OP_NW, OP_NE: rho = density[CFG_NORTH];
      OP_SOUTH, OP_SW, OP_SE: rho = density[CFG_SOUTH];
      OP_WEST: rho = density[CFG_WEST];
      default: rho = density[CFG_EAST];
    endcase
    case (op)
      OP_NORTH: m = '{7, 3, 6, 2, 8, 4, 1, 5};
      OP_SOUTH: m = '{3, 7, 2, 6, 4, 8, 5, 1};
      OP_WEST:  m = '{1, 5, 2, 6, 8, 4, 7, 3};
      OP_EAST:  m = '{5, 1, 6, 2, 4, 8, 3, 7};
      OP_NW:    m = '{1, 5, 7, 3, 8, 4, 2, 6};
      OP_NE:    m = '{5, 1, 6, 2, 7, 3, 4, 8};
      OP_SW:    m = '{1, 5, 2, 6, 3, 7, 4, 8};
      default:  m = '{3, 7, 4, 8, 5, 1, 2, 6};
    endcase
    if (op < OP_NW) begin
      if (rho > 0) begin
        s = f[0] + f[m[6]] + f[m[7]] + 2 * (f[m[1]] + f[m[3]] + f[m[5]]);
        q = rho - s;
        t = 3 * (f[m[6]] - f[m[7]]);
        o[m[0]] = clamp32(round_div(3 * f[m[1]] + 2 * q, 3));
        o[m[2]] = clamp32(round_div(6 * f[m[3]] + q + t, 6));
        o[m[4]] = clamp32(round_div(6 * f[m[5]] + q - t, 6));
      end else begin
        o[m[0]] = '0; o[m[2]] = '0; o[m[4]] = '0;
      end
    end else begin
      if (rho > 0) begin
        v = clamp32(round_div(rho - f[0] - 2 * (f[m[1]] + f[m[3]] + f[m[5]]), 2));
        o[m[0]] = f[m[1]][31:0]; o[m[2]] = f[m[3]][31:0]; o[m[4]] = f[m[5]][31:0];
        o[m[6]] = v; o[m[7]] = v;
      end else begin
        o[m[0]] = '0; o[m[2]] = '0; o[m[4]] = '0; o[m[6]] = '0; o[m[7]] = '0;
      end
    end
    r = '{o[0], o[1], o[2], o[3], o[4], o[5], o[6], o[7], o[8]};
    return r;
  endfunction

  // Driver: a valid stays up and its payload stays put until the transfer.
  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && !item_stall) begin
        expected_cells.push_back(boundary_rule(item));
      end
      if (!item_valid || !item_stall) begin
        if (pending_cells.size() > 0 && !hold_send &&
            $urandom_range(99) >= send_idle_pct) begin
          item <= pending_cells.pop_front();
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
      result_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Monitor.
  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && result_valid && !result_stall) begin
      if (expected_cells.size() == 0) begin
        $display("%0t: unexpected result %h", $time, result);
        errors++;
      end else begin
        exp_r = expected_cells.pop_front();
        for (int i = 0; i < 9; i++) begin
          if (exp_r[32*i +: 32] !== result[32*i +: 32]) begin
            $display("%0t: dist_out_%0d expected %h actual %h", $time, 8 - i,
                     exp_r[32*i +: 32], result[32*i +: 32]);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3, 4: return $urandom;
      default: return 32'($signed($urandom_range(32'h0c000000))) - 32'sh02000000;
    endcase
  endfunction

  function automatic item_t make_cell(input logic [2:0] op, input bit wild);
    item_t c;
    c.operation = op;
    c.dist_in_0 = wild ? pick_value() : $urandom_range(32'h04000000);
    c.dist_in_1 = wild ? pick_value() : $urandom_range(32'h01000000);
    c.dist_in_2 = wild ? pick_value() : $urandom_range(32'h01000000);
    c.dist_in_3 = wild ? pick_value() : $urandom_range(32'h01000000);
    c.dist_in_4 = wild ? pick_value() : $urandom_range(32'h01000000);
    c.dist_in_5 = wild ? pick_value() : $urandom_range(32'h01000000);
    c.dist_in_6 = wild ? pick_value() : $urandom_range(32'h01000000);
    c.dist_in_7 = wild ? pick_value() : $urandom_range(32'h01000000);
    c.dist_in_8 = wild ? pick_value() : $urandom_range(32'h01000000);
    return c;
  endfunction

  task automatic drain();
    wait (pending_cells.size() == 0);
    @(posedge clk);
    while (item_valid || expected_cells.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_density(input cfg_e idx, input logic [31:0] v);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    density[idx] = v;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    item_t c;
    logic [31:0] settings [5][4];
    settings[0] = '{32'h08000000, 32'h08000000, 32'h08000000, 32'h08000000};
    settings[1] = '{32'h7fffffff, 32'h00000001, 32'h0, 32'h80000000};
    settings[2] = '{32'h80000000, 32'hffffffff, 32'h7fffffff, 32'h00000001};
    settings[3] = '{32'h0c000000, 32'h04000000, 32'h10000000, 32'h06000000};
    settings[4] = '{32'h0, 32'h7fffffff, 32'h00000003, 32'h0a000000};
    for (int i = 0; i < 4; i++) density[i] = 32'sh08000000;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int op = 0; op < 8; op++) pending_cells.push_back(make_cell(3'(op), 1'b0));
    c = '0;
    for (int op = 0; op < 8; op++) begin
      c = {3'(op), {9{32'h7fffffff}}};
      pending_cells.push_back(c);
      c = {3'(op), {9{32'h80000000}}};
      pending_cells.push_back(c);
    end
    drain();
    for (int k = 1; k < 5; k++) begin
      for (int i = 0; i < 4; i++) set_density(cfg_e'(i), settings[k][i]);
      for (int op = 0; op < 8; op++) pending_cells.push_back(make_cell(3'(op), 1'b1));
      drain();
    end

    for (int k = 0; k < 5; k++) begin
      for (int i = 0; i < 4; i++) set_density(cfg_e'(i), settings[(k + 3) % 5][i]);
      if (k == 0) begin
        send_idle_pct = 33; recv_idle_pct = 51;
      end else if (k == 1) begin
        send_idle_pct = 51; recv_idle_pct = 33;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      for (int n = 0; n < 130; n++) begin
        pending_cells.push_back(make_cell(3'($urandom_range(7)), $urandom_range(3) == 0));
        if (n == 60) begin
          wait (pending_cells.size() == 0);
          hold_send = 1'b1;
          @(posedge clk);
          while (item_valid || expected_cells.size() != 0) @(posedge clk);
          hold_send = 1'b0;
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
